@@ sv/priority_slot_allocator_evict_top_macros.svh @@
// ----------------------------------------------------------------------------
// priority_slot_allocator_evict_top_macros
// Assertion macros used by the slot allocator checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SLOT_ALLOCATOR_EVICT_TOP_MACROS_SVH
`define PRIORITY_SLOT_ALLOCATOR_EVICT_TOP_MACROS_SVH

// same-cycle implication
`define PSAE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psae assertion failed");

// next-cycle implication
`define PSAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psae assertion failed");

`endif

@@ sv/psae_pkg.sv @@
// ----------------------------------------------------------------------------
// psae_pkg
// Shared widths, codes and types of the priority slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psae_pkg;

   localparam int SLOT_FW = 6;
   localparam int PRIO_W  = 8;
   localparam int ACT_W   = 7;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam int REG_IDX_W = ADDR_W - 2;

   localparam logic [ACT_W-1:0]     ACTIVE_RESET     = 7'd64;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_SLOTS = 1'b0;

   localparam logic REQ_STORE   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic             wr;
      logic [ACT_W-1:0] eff;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_FW-1:0] granted_slot;
      logic               evicted;
      logic [SLOT_FW-1:0] evicted_slot;
      logic               status;
   } result_type;

endpackage

`default_nettype wire

@@ sv/psae_chan_if.sv @@
// ----------------------------------------------------------------------------
// psae_chan_if
// Request and response channels of the slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface psae_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [psae_pkg::PRIO_W-1:0]   priority_req;
   logic [psae_pkg::SLOT_FW-1:0]  slot;

   modport source (output valid, req_type, priority_req, slot, input ready);
   modport sink   (input valid, req_type, priority_req, slot, output ready);
endinterface

interface psae_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psae_pkg::SLOT_FW-1:0]  granted_slot;
   logic                          evicted;
   logic [psae_pkg::SLOT_FW-1:0]  evicted_slot;
   logic                          status;

   modport source (output valid, granted_slot, evicted, evicted_slot, status,
                   input ready);
   modport sink   (input valid, granted_slot, evicted, evicted_slot, status,
                   output ready);
endinterface

`default_nettype wire

@@ sv/psae_csr.sv @@
// ----------------------------------------------------------------------------
// psae_csr
// APB register block: active_slots and the clamped effective slot count.
// ----------------------------------------------------------------------------
`default_nettype none

module psae_csr #(
   parameter int SLOT_COUNT = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [psae_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [psae_pkg::DATA_W-1:0]  pwdata,
   output      logic [psae_pkg::DATA_W-1:0]  prdata,
   output      logic                         pready,
   output      psae_pkg::cfg_type            cfg
);
   import psae_pkg::*;

   localparam int ACT_MAX = (1 << ACT_W) - 1;
   localparam int LIMIT   = (SLOT_COUNT > ACT_MAX) ? ACT_MAX : SLOT_COUNT;
   localparam logic [ACT_W-1:0] LIMIT_VAL = ACT_W'(LIMIT);

   logic [ACT_W-1:0]     active_ff;
   logic [ACT_W-1:0]     active_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 hit;
   logic                 wr;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign hit     = (reg_idx == REG_ACTIVE_SLOTS);
   assign pready  = 1'b1;
   assign wr      = psel & penable & pwrite & pready & hit;

   assign active_in = wr ? pwdata[ACT_W-1:0] : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      cfg.wr = wr;
      if (active_ff == '0) begin
         cfg.eff = ACT_W'(1);
      end else if (active_ff > LIMIT_VAL) begin
         cfg.eff = LIMIT_VAL;
      end else begin
         cfg.eff = active_ff;
      end
   end

   assign prdata = hit ? DATA_W'(active_ff) : '0;

endmodule

`default_nettype wire

@@ sv/psae_ctrl.sv @@
// ----------------------------------------------------------------------------
// psae_ctrl
// Sequencer and slot state: free stack, per-slot links, class heads.
// ----------------------------------------------------------------------------
`default_nettype none

module psae_ctrl #(
   parameter int SLOT_COUNT  = 64,
   parameter int CLASS_COUNT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psae_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_type,
   input  wire logic [psae_pkg::PRIO_W-1:0]   priority_req,
   input  wire logic [psae_pkg::SLOT_FW-1:0]  slot,
   input  wire logic                          out_free,
   output      logic                          done,
   output      psae_pkg::result_type          result
);
   import psae_pkg::*;

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int LINK_W  = SLOT_W + 1;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int CLASS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

   localparam logic [LINK_W-1:0]  NIL_LINK    = LINK_W'(SLOT_COUNT);
   localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [CLASS_W-1:0] TOP_CLASS   = CLASS_W'(CLASS_COUNT - 1);
   localparam logic [PRIO_W-1:0]  CLASS_LIMIT = PRIO_W'(CLASS_COUNT);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VICTIM,
      ST_LOOKUP,
      ST_UNLINK,
      ST_FETCH,
      ST_APPEND1,
      ST_APPEND2,
      ST_FINISH
   } state_type;

   // memories
   logic [LINK_W-1:0]  older_mem  [SLOT_COUNT];
   logic [LINK_W-1:0]  newer_mem  [SLOT_COUNT];
   logic [CLASS_W-1:0] class_mem  [SLOT_COUNT];
   logic               inuse_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0]  stack_mem  [SLOT_COUNT];
   logic [SLOT_W-1:0]  newest_mem [CLASS_COUNT];

   logic [LINK_W-1:0]  older_rd_ff;
   logic [LINK_W-1:0]  newer_rd_ff;
   logic [CLASS_W-1:0] class_rd_ff;
   logic               inuse_rd_ff;
   logic [SLOT_W-1:0]  stack_rd_ff;
   logic [SLOT_W-1:0]  newest_rd_ff;

   logic               older_we,  newer_we,  class_we,  inuse_we,  stack_we, newest_we;
   logic [SLOT_W-1:0]  older_wa,  newer_wa,  class_wa,  inuse_wa,  stack_wa;
   logic [CLASS_W-1:0] newest_wa;
   logic [LINK_W-1:0]  older_wd,  newer_wd;
   logic [CLASS_W-1:0] class_wd;
   logic               inuse_wd;
   logic [SLOT_W-1:0]  stack_wd,  newest_wd;

   logic [SLOT_W-1:0]  slot_ra;
   logic [SLOT_W-1:0]  stack_ra;
   logic [CLASS_W-1:0] newest_ra;

   // sequencer registers
   state_type            state_ff,    state_in;
   logic [SLOT_W-1:0]    clr_ff,      clr_in;
   logic [CNT_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [CLASS_COUNT-1:0] nonempty_ff, nonempty_in;
   logic                 is_rel_ff,   is_rel_in;
   logic                 is_ev_ff,    is_ev_in;
   logic [CLASS_W-1:0]   cls_ff,      cls_in;
   logic [SLOT_FW-1:0]   slot_ff,     slot_in;
   logic [SLOT_W-1:0]    cur_ff,      cur_in;
   logic [SLOT_W-1:0]    grant_ff,    grant_in;
   logic [SLOT_W-1:0]    tail_ff,     tail_in;
   logic                 tail_ok_ff,  tail_ok_in;
   logic                 status_ff,   status_in;

   logic [CLASS_W-1:0]   victim;
   logic [SLOT_W-1:0]    look_addr;
   logic [SLOT_W-1:0]    pick;
   logic                 unlink_ok;
   logic                 o_ok;
   logic                 w_ok;
   logic                 accept;

   always_comb begin
      victim = '0;
      for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            victim = CLASS_W'(i);
         end
      end
   end

   assign look_addr = is_ev_ff ? newest_rd_ff : SLOT_W'(slot_ff);
   assign pick      = is_ev_ff ? cur_ff : stack_rd_ff;
   assign o_ok      = older_rd_ff < NIL_LINK;
   assign w_ok      = newer_rd_ff < NIL_LINK;
   assign unlink_ok = !is_rel_ff || ((ACT_W'(slot_ff) < cfg.eff) && inuse_rd_ff);

   assign slot_ra   = look_addr;
   assign stack_ra  = SLOT_W'(free_cnt_ff - CNT_W'(1));
   assign newest_ra = (state_ff == ST_VICTIM) ? victim : cls_ff;

   assign req_ready = (state_ff == ST_IDLE) && !cfg.wr;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      free_cnt_in = free_cnt_ff;
      nonempty_in = nonempty_ff;
      is_rel_in   = is_rel_ff;
      is_ev_in    = is_ev_ff;
      cls_in      = cls_ff;
      slot_in     = slot_ff;
      cur_in      = cur_ff;
      grant_in    = grant_ff;
      tail_in     = tail_ff;
      tail_ok_in  = tail_ok_ff;
      status_in   = status_ff;
      done        = 1'b0;

      older_we  = 1'b0; older_wa  = '0; older_wd  = '0;
      newer_we  = 1'b0; newer_wa  = '0; newer_wd  = '0;
      class_we  = 1'b0; class_wa  = '0; class_wd  = '0;
      inuse_we  = 1'b0; inuse_wa  = '0; inuse_wd  = 1'b0;
      stack_we  = 1'b0; stack_wa  = '0; stack_wd  = '0;
      newest_we = 1'b0; newest_wa = '0; newest_wd = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            stack_we = 1'b1;
            stack_wa = clr_ff;
            stack_wd = clr_ff;
            inuse_we = 1'b1;
            inuse_wa = clr_ff;
            inuse_wd = 1'b0;
            clr_in   = clr_ff + SLOT_W'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in    = ST_IDLE;
               free_cnt_in = CNT_W'(cfg.eff);
               nonempty_in = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               slot_in   = slot;
               is_rel_in = (req_type == REQ_RELEASE);
               is_ev_in  = (req_type == REQ_STORE) && (free_cnt_ff == '0);
               status_in = STATUS_OK;
               if (priority_req >= CLASS_LIMIT) begin
                  cls_in = TOP_CLASS;
               end else begin
                  cls_in = CLASS_W'(priority_req);
               end
               if (req_type == REQ_RELEASE) begin
                  state_in = ST_LOOKUP;
               end else if (free_cnt_ff == '0) begin
                  state_in = ST_VICTIM;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_VICTIM: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cur_in   = look_addr;
            state_in = ST_UNLINK;
         end
         ST_UNLINK: begin
            if (unlink_ok) begin
               inuse_we = 1'b1;
               inuse_wa = cur_ff;
               inuse_wd = 1'b0;
               if (o_ok) begin
                  newer_we = 1'b1;
                  newer_wa = older_rd_ff[SLOT_W-1:0];
                  newer_wd = newer_rd_ff;
               end
               if (w_ok) begin
                  older_we = 1'b1;
                  older_wa = newer_rd_ff[SLOT_W-1:0];
                  older_wd = older_rd_ff;
               end else if (o_ok) begin
                  newest_we = 1'b1;
                  newest_wa = class_rd_ff;
                  newest_wd = older_rd_ff[SLOT_W-1:0];
               end else begin
                  nonempty_in[class_rd_ff] = 1'b0;
               end
               // an evicted slot is pushed and popped again at once: skip both
               if (is_rel_ff) begin
                  stack_we    = 1'b1;
                  stack_wa    = SLOT_W'(free_cnt_ff);
                  stack_wd    = cur_ff;
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end else begin
               status_in = STATUS_BAD;
            end
            state_in = is_ev_ff ? ST_FETCH : ST_FINISH;
         end
         ST_FETCH: begin
            state_in = ST_APPEND1;
         end
         ST_APPEND1: begin
            grant_in   = pick;
            tail_in    = newest_rd_ff;
            tail_ok_in = nonempty_ff[cls_ff];
            class_we   = 1'b1;
            class_wa   = pick;
            class_wd   = cls_ff;
            inuse_we   = 1'b1;
            inuse_wa   = pick;
            inuse_wd   = 1'b1;
            older_we   = 1'b1;
            older_wa   = pick;
            older_wd   = nonempty_ff[cls_ff] ? LINK_W'(newest_rd_ff) : NIL_LINK;
            newer_we   = 1'b1;
            newer_wa   = pick;
            newer_wd   = NIL_LINK;
            if (!is_ev_ff) begin
               free_cnt_in = free_cnt_ff - CNT_W'(1);
            end
            state_in = ST_APPEND2;
         end
         ST_APPEND2: begin
            if (tail_ok_ff) begin
               newer_we = 1'b1;
               newer_wa = tail_ff;
               newer_wd = LINK_W'(grant_ff);
            end
            newest_we           = 1'b1;
            newest_wa           = cls_ff;
            newest_wd           = grant_ff;
            nonempty_in[cls_ff] = 1'b1;
            state_in            = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      if (cfg.wr) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   always_comb begin
      result.granted_slot = is_rel_ff ? slot_ff : SLOT_FW'(grant_ff);
      result.evicted      = is_ev_ff;
      result.evicted_slot = is_ev_ff ? SLOT_FW'(cur_ff) : '0;
      result.status       = status_ff;
   end

   always_ff @(posedge clock) begin
      state_ff    <= state_in;
      clr_ff      <= clr_in;
      free_cnt_ff <= free_cnt_in;
      nonempty_ff <= nonempty_in;
      is_rel_ff   <= is_rel_in;
      is_ev_ff    <= is_ev_in;
      cls_ff      <= cls_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      grant_ff    <= grant_in;
      tail_ff     <= tail_in;
      tail_ok_ff  <= tail_ok_in;
      status_ff   <= status_in;
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         free_cnt_ff <= '0;
         nonempty_ff <= '0;
         is_rel_ff   <= 1'b0;
         is_ev_ff    <= 1'b0;
         status_ff   <= STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_wa] <= older_wd;
      end
      older_rd_ff <= older_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[newer_wa] <= newer_wd;
      end
      newer_rd_ff <= newer_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[class_wa] <= class_wd;
      end
      class_rd_ff <= class_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (inuse_we) begin
         inuse_mem[inuse_wa] <= inuse_wd;
      end
      inuse_rd_ff <= inuse_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (newest_we) begin
         newest_mem[newest_wa] <= newest_wd;
      end
      newest_rd_ff <= newest_mem[newest_ra];
   end

endmodule

`default_nettype wire

@@ sv/priority_slot_allocator_evict_top.sv @@
// ----------------------------------------------------------------------------
// priority_slot_allocator_evict_top
// Cache slot allocator: LIFO free stack, per-class insertion lists,
// eviction of the newest slot of the lowest non-empty class.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid/ready        req_type, priority_req, slot
//   rsp_ch    out   valid/ready        granted_slot, evicted, evicted_slot, status
//   apb       in    psel/penable       paddr, pwdata, prdata (active_slots)
//
// Release unlinks its slot; store pops and appends one; eviction unlinks first.
// The sequencer walks the slot state one memory access per step; each
// per-slot memory has one write and one registered read port.
// After reset and after each write of active_slots a clearing pass over
// all SLOT_COUNT slots rebuilds the free stack; req_ch is not ready meanwhile.
// A stalled rsp_ch holds the sequencer in its last step; one finished result
// waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_slot_allocator_evict_top #(
   parameter int SLOT_COUNT  = 64,
   parameter int CLASS_COUNT = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   psae_req_if.sink                          req_ch,
   psae_rsp_if.source                        rsp_ch,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [psae_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [psae_pkg::DATA_W-1:0]  pwdata,
   output      logic [psae_pkg::DATA_W-1:0]  prdata,
   output      logic                         pready
);
   import psae_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       done;
   logic       out_free;
   logic       req_ready;

   psae_csr #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   psae_ctrl #(
      .SLOT_COUNT  (SLOT_COUNT),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ready),
      .req_type     (req_ch.req_type),
      .priority_req (req_ch.priority_req),
      .slot         (req_ch.slot),
      .out_free     (out_free),
      .done         (done),
      .result       (result)
   );

   assign req_ch.ready = req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      rsp_valid_ff <= rsp_valid_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted_slot = rsp_ff.granted_slot;
   assign rsp_ch.evicted      = rsp_ff.evicted;
   assign rsp_ch.evicted_slot = rsp_ff.evicted_slot;
   assign rsp_ch.status       = rsp_ff.status;

endmodule

`default_nettype wire

@@ sv/psae_checker.sv @@
// ----------------------------------------------------------------------------
// psae_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_slot_allocator_evict_top_macros.svh"

module psae_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [psae_pkg::SLOT_FW-1:0]  rsp_granted_slot,
   input wire logic                          rsp_evicted,
   input wire logic [psae_pkg::SLOT_FW-1:0]  rsp_evicted_slot,
   input wire logic                          rsp_status
);
   import psae_pkg::*;

   // stalled response holds
   `PSAE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_slot) && $stable(rsp_evicted) && $stable(rsp_evicted_slot) && $stable(rsp_status))

   // one request at a time
   `PSAE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // evicted slot is granted again, never with an error
   `PSAE_ASSERT_NOW(a_evict_regrant, clock, reset, rsp_valid && rsp_evicted, (rsp_granted_slot == rsp_evicted_slot) && (rsp_status == STATUS_OK))

   `PSAE_ASSERT_NOW(a_no_evict_zero, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_slot == '0)

endmodule

bind priority_slot_allocator_evict_top psae_checker u_psae_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_granted_slot (rsp_ch.granted_slot),
   .rsp_evicted      (rsp_ch.evicted),
   .rsp_evicted_slot (rsp_ch.evicted_slot),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire

@@ dv/psae_alloc_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psae_alloc_check
// Watches the request, response and register ports of the slot allocator,
// keeps its own copy of the free stack and class lists, predicts every
// response and compares it, in order, against what the block returns.
// ----------------------------------------------------------------------------

module psae_alloc_check #(
   parameter int SLOT_COUNT  = 64,
   parameter int CLASS_COUNT = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   psae_req_if                               req_mon,
   psae_rsp_if                               rsp_mon,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic                         pready,
   input  wire logic [psae_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [psae_pkg::DATA_W-1:0]  pwdata,
   output int                                fail_count,
   output int                                pending
);
   import psae_pkg::*;

   localparam int LINK_W = $clog2(SLOT_COUNT + 1);
   localparam int CLS_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOT_COUNT);

   logic [ACT_W-1:0]  act_slots;
   logic [LINK_W-1:0] free_stack [SLOT_COUNT];
   int                free_cnt;
   logic              in_use     [SLOT_COUNT];
   logic [CLS_W-1:0]  slot_cls   [SLOT_COUNT];
   logic [LINK_W-1:0] older      [SLOT_COUNT];
   logic [LINK_W-1:0] newer      [SLOT_COUNT];
   logic [LINK_W-1:0] cls_newest [CLASS_COUNT];
   logic [LINK_W-1:0] cls_oldest [CLASS_COUNT];

   result_type pending_grants [$];
   int         errs = 0;

   function automatic int eff_slots();
      int n;
      n = act_slots;
      if (n == 0) n = 1;
      if (n > SLOT_COUNT) n = SLOT_COUNT;
      return n;
   endfunction

   function automatic void rebuild();
      int n;
      n = eff_slots();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         free_stack[i] = (i < n) ? LINK_W'(i) : '0;
         in_use[i]     = 1'b0;
         slot_cls[i]   = '0;
         older[i]      = NIL;
         newer[i]      = NIL;
      end
      for (int k = 0; k < CLASS_COUNT; k++) begin
         cls_newest[k] = NIL;
         cls_oldest[k] = NIL;
      end
      free_cnt = n;
   endfunction

   function automatic void push_free(input int s);
      if (free_cnt < SLOT_COUNT) begin
         free_stack[free_cnt] = LINK_W'(s);
         free_cnt++;
      end
   endfunction

   function automatic void unlink(input int s);
      int c;
      int o;
      int w;
      c = slot_cls[s];
      o = older[s];
      w = newer[s];
      if (o < SLOT_COUNT) newer[o] = LINK_W'(w);
      else cls_oldest[c] = LINK_W'(w);
      if (w < SLOT_COUNT) older[w] = LINK_W'(o);
      else cls_newest[c] = LINK_W'(o);
      older[s]  = NIL;
      newer[s]  = NIL;
      in_use[s] = 1'b0;
   endfunction

   function automatic void append(input int s, input int c);
      int t;
      t = cls_newest[c];
      slot_cls[s] = CLS_W'(c);
      older[s]    = LINK_W'(t);
      newer[s]    = NIL;
      if (t < SLOT_COUNT) newer[t] = LINK_W'(s);
      else cls_oldest[c] = LINK_W'(s);
      cls_newest[c] = LINK_W'(s);
      in_use[s]     = 1'b1;
   endfunction

   function automatic result_type alloc_predict(input logic kind,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [SLOT_FW-1:0] s);
      result_type r;
      int c;
      int g;
      int v;
      logic found;
      r = '0;
      r.status = STATUS_OK;
      if (kind == REQ_STORE) begin
         c = (prio >= CLASS_COUNT) ? CLASS_COUNT - 1 : int'(prio);
         if (free_cnt == 0) begin
            found = 1'b0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
               v = cls_newest[k];
               if (!found && v < SLOT_COUNT) begin
                  unlink(v);
                  push_free(v);
                  r.evicted      = 1'b1;
                  r.evicted_slot = SLOT_FW'(v);
                  found          = 1'b1;
               end
            end
         end
         if (free_cnt > 0) begin
            free_cnt--;
            g = free_stack[free_cnt];
            if (g < SLOT_COUNT) append(g, c);
            r.granted_slot = SLOT_FW'(g);
         end
      end else begin
         r.granted_slot = s;
         if (s < eff_slots() && in_use[s]) begin
            unlink(s);
            push_free(s);
         end else begin
            r.status = STATUS_BAD;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         act_slots = ACTIVE_RESET;
         rebuild();
         pending_grants.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr[ADDR_W-1:2] == REG_ACTIVE_SLOTS) begin
            act_slots = pwdata[ACT_W-1:0];
            rebuild();
         end
         if (req_mon.valid && req_mon.ready)
            pending_grants.push_back(alloc_predict(req_mon.req_type,
                                                   req_mon.priority_req,
                                                   req_mon.slot));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.granted_slot = rsp_mon.granted_slot;
            got.evicted      = rsp_mon.evicted;
            got.evicted_slot = rsp_mon.evicted_slot;
            got.status       = rsp_mon.status;
            if (pending_grants.size() == 0) begin
               if (errs < 10)
                  $display("%0t: unexpected transfer granted %0d evicted %0d/%0d status %0d",
                           $time, got.granted_slot, got.evicted, got.evicted_slot,
                           got.status);
               errs++;
            end else begin
               want = pending_grants.pop_front();
               if (got.granted_slot !== want.granted_slot ||
                   got.evicted      !== want.evicted      ||
                   got.evicted_slot !== want.evicted_slot ||
                   got.status       !== want.status) begin
                  if (errs < 10)
                     $display("%0t: exp %0d %0d/%0d %0d, got %0d %0d/%0d %0d",
                              $time, want.granted_slot, want.evicted, want.evicted_slot,
                              want.status, got.granted_slot, got.evicted,
                              got.evicted_slot, got.status);
                  errs++;
               end
            end
         end
      end
      fail_count <= errs;
      pending    <= pending_grants.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the slot allocator: directed stores and releases around full and
// empty stacks, then random traffic over several active slot counts, with
// bursty requests, a stalling response side and one long response hold-off.
// ----------------------------------------------------------------------------

module tb;
   import psae_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  pending;
   int                  burst_left = 0;
   logic                random_phase = 1'b0;
   logic                long_hold_done = 1'b0;
   int unsigned         phase_cfg [10] = '{3, 64, 1, 8, 127, 2, 17, 64, 5, 40};

   psae_req_if req_if ();
   psae_rsp_if rsp_if ();

   priority_slot_allocator_evict_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   psae_alloc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one request transfer; opens a new burst with an optional gap first
   task automatic send_req(input logic kind, input logic [PRIO_W-1:0] prio,
                           input logic [SLOT_FW-1:0] slot_no);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.req_type     <= kind;
      req_if.priority_req <= prio;
      req_if.slot         <= slot_no;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // drains all outstanding responses, then writes one register
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      burst_left = 0;
   endtask

   initial begin
      int eff;
      int store_pct;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_STORE;
      req_if.priority_req <= '0;
      req_if.slot         <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full stack after reset: grants come from the top, class clamp
      send_req(REQ_STORE, 8'd0, 6'd0);
      send_req(REQ_STORE, 8'd255, 6'd63);
      send_req(REQ_STORE, 8'd7, 6'd0);
      send_req(REQ_STORE, 8'd8, 6'd21);
      send_req(REQ_STORE, 8'd3, 6'd42);
      send_req(REQ_RELEASE, 8'd0, 6'd62);
      send_req(REQ_RELEASE, 8'd255, 6'd62);
      send_req(REQ_RELEASE, 8'd0, 6'd0);
      send_req(REQ_RELEASE, 8'd0, 6'd63);

      // two slots, upper data bits set: eviction and out-of-range release
      write_reg(REG_ACTIVE_SLOTS, 32'hFFFF_FF82);
      send_req(REQ_STORE, 8'd1, 6'd0);
      send_req(REQ_STORE, 8'd0, 6'd0);
      send_req(REQ_STORE, 8'd5, 6'd0);
      send_req(REQ_RELEASE, 8'd0, 6'd5);
      send_req(REQ_RELEASE, 8'd0, 6'd63);
      send_req(REQ_STORE, 8'd255, 6'd0);

      // zero count behaves as one slot
      write_reg(REG_ACTIVE_SLOTS, 32'd0);
      send_req(REQ_STORE, 8'd2, 6'd0);
      send_req(REQ_STORE, 8'd6, 6'd0);
      send_req(REQ_RELEASE, 8'd0, 6'd0);
      send_req(REQ_RELEASE, 8'd0, 6'd0);
      send_req(REQ_RELEASE, 8'd0, 6'd1);

      // unmapped register write leaves the allocator alone
      write_reg(REG_UNMAPPED, 32'd3);
      send_req(REQ_STORE, 8'd4, 6'd0);
      send_req(REQ_STORE, 8'd0, 6'd0);

      foreach (phase_cfg[ph]) begin
         write_reg(REG_ACTIVE_SLOTS, phase_cfg[ph]);
         random_phase = 1'b1;
         eff = (phase_cfg[ph] == 0) ? 1 : (phase_cfg[ph] > 64) ? 64 : phase_cfg[ph];
         store_pct = (eff >= 32) ? 85 : 55;
         repeat (200) begin
            if ($urandom_range(0, 99) < store_pct)
               send_req(REQ_STORE,
                        ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 7)),
                        6'($urandom_range(0, 63)));
            else
               send_req(REQ_RELEASE, 8'($urandom_range(0, 255)),
                        ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, eff - 1)));
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("priority_slot_allocator_evict_top: match");
      else
         $display("priority_slot_allocator_evict_top: mismatch");
      $finish;
   end

   // response side: ready runs, short stalls, rare long ones, one forced hold-off
   initial begin
      int r;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (random_phase && !long_hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (r < 2) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(60, 150)) @(posedge clock);
         end else if (r < 45) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, (r < 90) ? 12 : 80)) @(posedge clock);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("priority_slot_allocator_evict_top: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/psae_pkg.sv
sv/psae_chan_if.sv
sv/psae_csr.sv
sv/psae_ctrl.sv
sv/priority_slot_allocator_evict_top.sv
sv/psae_checker.sv
dv/psae_alloc_check.sv
dv/tb.sv
